[rtl/core/far_pkg.sv]
// Package for the fraction arithmetic unit: opcodes and sequencer states.
`default_nettype none

package far_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL0  = 9'b000000010,
    S_MUL1  = 9'b000000100,
    S_MUL2  = 9'b000001000,
    S_CHECK = 9'b000010000,
    S_GCD   = 9'b000100000,
    S_DIVN  = 9'b001000000,
    S_DIVD  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_ZERO_DEN = 1'b1;

endpackage : far_pkg

`default_nettype wire

[rtl/core/fraction_arith_reduce_unit.sv]
// Fraction add/sub/mul/div with reduction to lowest terms, one shared subtractor.
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------
//   in      | in_valid, in_stall  | opcode, a_num, a_den, b_num, b_den
//   out     | out_valid, out_stall| res_num, res_den, status
//
// One item at a time: multiply (S_MUL0..S_MUL2, one shared W x W multiplier), check,
// binary-gcd and 2 * 2*W restoring divide steps, all on one (2W+1)-bit subtractor.
// A zero denominator or zero numerator skips the gcd and divide phases.
// in_stall is high from acceptance until the result item is taken, and in reset.
// rst is synchronous and returns the sequencer to idle; no clearing pass.
`default_nettype none

module fraction_arith_reduce_unit #(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire        [1:0]                 opcode,
  input  wire signed [OPERAND_WIDTH-1:0]   a_num,
  input  wire signed [OPERAND_WIDTH-1:0]   a_den,
  input  wire signed [OPERAND_WIDTH-1:0]   b_num,
  input  wire signed [OPERAND_WIDTH-1:0]   b_den,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic signed [2*OPERAND_WIDTH:0]  res_num,
  output logic       [2*OPERAND_WIDTH-1:0] res_den,
  output logic                             status
);

  localparam int W  = OPERAND_WIDTH;
  localparam int DW = 2 * W;
  localparam int NW = DW + 1;
  localparam int SW = DW + 1;
  localparam int CW = $clog2(DW);

  far_pkg::state_t state;
  far_pkg::op_t    op;

  logic signed [W-1:0]  an, ad, bn, bd;
  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [DW-1:0] prod;
  logic signed [DW-1:0] mul_out;
  logic signed [NW-1:0] n;
  logic                 neg;
  logic [DW-1:0]        nm, dm, x, y, g, quo, rem;
  logic [CW-1:0]        k, cnt;

  logic [SW-1:0]        sub_a, sub_b;
  logic [SW:0]          diff;
  logic                 borrow;
  logic [DW-1:0]        dlow, dneg, q_next;
  logic [NW-1:0]        n_neg;
  logic [DW-1:0]        n_mag, d_mag, d_neg;

  // shared multiplier operand select
  always_comb begin
    case (state)
      far_pkg::S_MUL1: begin
        mul_a = bn;
        mul_b = ad;
      end
      far_pkg::S_MUL2: begin
        mul_a = ad;
        mul_b = (op == far_pkg::OP_DIV) ? bn : bd;
      end
      default: begin
        mul_a = an;
        mul_b = (op == far_pkg::OP_MUL) ? bn : bd;
      end
    endcase
  end

  assign mul_out = DW'(mul_a) * DW'(mul_b);

  // shared subtractor: gcd compare/subtract or divide step
  always_comb begin
    if (state == far_pkg::S_DIVN || state == far_pkg::S_DIVD) begin
      sub_a = {rem, quo[DW-1]};
      sub_b = {1'b0, g};
    end else begin
      sub_a = {1'b0, x};
      sub_b = {1'b0, y};
    end
  end

  assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow = diff[SW];
  assign dlow   = diff[DW-1:0];
  assign dneg   = {DW{1'b0}} - dlow;
  assign q_next = {quo[DW-2:0], ~borrow};

  assign n_neg = {NW{1'b0}} - n;
  assign n_mag = n[NW-1] ? n_neg[DW-1:0] : n[DW-1:0];
  assign d_neg = {DW{1'b0}} - prod;
  assign d_mag = prod[DW-1] ? d_neg : prod;

  assign in_stall  = rst || (state != far_pkg::S_IDLE);
  assign out_valid = (state == far_pkg::S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= far_pkg::S_IDLE;
    end else begin
      case (state)
        far_pkg::S_IDLE: begin
          if (in_valid) begin
            op    <= far_pkg::op_t'(opcode);
            an    <= a_num;
            ad    <= a_den;
            bn    <= b_num;
            bd    <= b_den;
            state <= far_pkg::S_MUL0;
          end
        end
        far_pkg::S_MUL0: begin
          prod  <= mul_out;
          state <= far_pkg::S_MUL1;
        end
        far_pkg::S_MUL1: begin
          n     <= {prod[DW-1], prod};
          prod  <= mul_out;
          state <= far_pkg::S_MUL2;
        end
        far_pkg::S_MUL2: begin
          case (op)
            far_pkg::OP_ADD: n <= n + {prod[DW-1], prod};
            far_pkg::OP_SUB: n <= n - {prod[DW-1], prod};
            default:         n <= n;
          endcase
          prod  <= mul_out;
          state <= far_pkg::S_CHECK;
        end
        far_pkg::S_CHECK: begin
          if (prod == '0) begin
            res_num <= '0;
            res_den <= '0;
            status  <= far_pkg::STATUS_ZERO_DEN;
            state   <= far_pkg::S_DONE;
          end else if (n == '0) begin
            res_num <= '0;
            res_den <= {{(DW-1){1'b0}}, 1'b1};
            status  <= far_pkg::STATUS_OK;
            state   <= far_pkg::S_DONE;
          end else begin
            neg   <= n[NW-1] ^ prod[DW-1];
            nm    <= n_mag;
            dm    <= d_mag;
            x     <= n_mag;
            y     <= d_mag;
            k     <= '0;
            state <= far_pkg::S_GCD;
          end
        end
        far_pkg::S_GCD: begin
          if (diff == '0) begin
            g     <= x << k;
            quo   <= nm;
            rem   <= '0;
            cnt   <= '0;
            state <= far_pkg::S_DIVN;
          end else if (!x[0] && !y[0]) begin
            x <= x >> 1;
            y <= y >> 1;
            k <= k + 1'b1;
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (borrow) begin
            y <= dneg >> 1;
          end else begin
            x <= dlow >> 1;
          end
        end
        far_pkg::S_DIVN: begin
          if (cnt == CW'(DW - 1)) begin
            res_num <= neg ? ({NW{1'b0}} - {1'b0, q_next}) : {1'b0, q_next};
            quo     <= dm;
            rem     <= '0;
            cnt     <= '0;
            state   <= far_pkg::S_DIVD;
          end else begin
            rem <= borrow ? sub_a[DW-1:0] : dlow;
            quo <= q_next;
            cnt <= cnt + 1'b1;
          end
        end
        far_pkg::S_DIVD: begin
          rem <= borrow ? sub_a[DW-1:0] : dlow;
          quo <= q_next;
          cnt <= cnt + 1'b1;
          if (cnt == CW'(DW - 1)) begin
            res_den <= q_next;
            status  <= far_pkg::STATUS_OK;
            state   <= far_pkg::S_DONE;
          end
        end
        far_pkg::S_DONE: begin
          if (!out_stall) begin
            state <= far_pkg::S_IDLE;
          end
        end
        default: begin
          state <= far_pkg::S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> res_num == '0 && res_den == '0)
    else $error("error item carries nonzero fields");

  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status |-> res_den != '0)
    else $error("ok item with zero denominator");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  a_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == far_pkg::S_MUL0)
    else $error("accepted item did not start multiply");

  a_gcd_nz: assert property (@(posedge clk) disable iff (rst)
    state == far_pkg::S_GCD |-> x != '0 && y != '0)
    else $error("gcd operand reached zero");
`endif

endmodule : fraction_arith_reduce_unit

`default_nettype wire
